/* src/crc8c_pkg.sv */
// crc8c_pkg: shared types, status codes and the crc8 byte update
// for the accessory block crc check; no dependencies
package crc8c_pkg;

  localparam logic [7:0] CRC_POLY    = 8'h85;
  localparam logic [7:0] CRC_ALLONES = 8'hFF;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NO_ACCESSORY = 2'd1;
  localparam logic [1:0] ST_BAD_CRC      = 2'd2;
  localparam logic [1:0] ST_UNUSED       = 2'd3;

  // one registered input word
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
    logic [7:0] rx_crc;
  } item_t;

  // shift one byte msb first into the crc register, shift-in form
  function automatic logic [7:0] crc8c_shift_byte(input logic [7:0] crc,
                                                  input logic [7:0] data);
    logic [7:0] r;
    logic [7:0] fb;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[7] ? CRC_POLY : 8'h00;
      r  = {r[6:0], data[k]} ^ fb;
    end
    return r;
  endfunction

endpackage

/* src/crc8c_in_stage.sv */
// crc8c_in_stage: input register for one word of the data block
// depends on crc8c_pkg
module crc8c_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  input  logic [7:0]           in_received_crc,
  input  logic                 take,
  output crc8c_pkg::item_t     item
);
  import crc8c_pkg::*;

  item_t item_r;

  // free when empty or when the held word moves on this cycle
  assign in_ready = !item_r.valid || take;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (in_ready) begin
      item_r.valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_r.last   <= in_last_byte;
      item_r.data   <= in_data_byte;
      item_r.rx_crc <= in_received_crc;
    end
  end

endmodule

/* src/crc8c_core.sv */
// crc8c_core: crc accumulator, final augmentation and compare, result register
// depends on crc8c_pkg
module crc8c_core (
  input  logic               clk,
  input  logic               rst_n,
  input  crc8c_pkg::item_t   item,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_check_status,
  output logic [7:0]         out_computed_crc
);
  import crc8c_pkg::*;

  logic [7:0] acc_r;
  logic [7:0] acc_upd;
  logic [7:0] final_crc;
  logic [1:0] status_nxt;
  logic       out_valid_r;
  logic [1:0] status_r;
  logic [7:0] crc_r;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;
  // non-last words only touch the accumulator, so they never wait on the output
  assign take     = item.valid && (!item.last || out_free);

  assign acc_upd   = crc8c_shift_byte(acc_r, item.data);
  assign final_crc = crc8c_shift_byte(acc_upd, 8'h00);

  always_comb begin
    if (final_crc == item.rx_crc) begin
      status_nxt = ST_OK;
    end else if (final_crc == (item.rx_crc ^ CRC_ALLONES)) begin
      status_nxt = ST_NO_ACCESSORY;
    end else begin
      status_nxt = ST_BAD_CRC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        acc_r <= item.last ? 8'h00 : acc_upd;
      end
      if (take && item.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (take && item.last) begin
      status_r <= status_nxt;
      crc_r    <= final_crc;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_check_status = status_r;
  assign out_computed_crc = crc_r;

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.last |=> acc_r == 8'h00)
    else $error("accumulator not cleared after last word");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> status_r != ST_UNUSED)
    else $error("unused status code on output");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(take && item.last))
    else $error("result raised without a last word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(take && item.last))
    else $error("pending result overwritten");

endmodule

/* src/accessory_block_crc8_check.sv */
// accessory_block_crc8_check: top level, crc8 (poly 0x85) check of a data block
// result: registered after the input register; a last word waits there while a result is pending
// throughput: one word per cycle unless a last word waits on a pending result; the byte update
//   and final zero-byte shift are xor logic between the input register and the result register
// reset: rst_n synchronous active low clears the crc accumulator and both valids
// depends on crc8c_pkg, crc8c_in_stage, crc8c_core
module accessory_block_crc8_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic [7:0] in_received_crc,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_check_status,
  output logic [7:0] out_computed_crc
);
  import crc8c_pkg::*;

  item_t item;
  logic  take;

  crc8c_in_stage u_in (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .in_received_crc (in_received_crc),
    .take            (take),
    .item            (item)
  );

  crc8c_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .item             (item),
    .take             (take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_check_status (out_check_status),
    .out_computed_crc (out_computed_crc)
  );

endmodule

/* tb/tb_accessory_block_crc8_check.sv */
// tb_accessory_block_crc8_check: self-checking bench for the crc8 (poly 0x85) block checker
// drives data blocks through valid/ready, predicts status and crc per last word
// depends on crc8c_pkg and accessory_block_crc8_check
module tb_accessory_block_crc8_check;
  import crc8c_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 80;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int SETTLE_CYCLES = 8;

  localparam int RX_GOOD = 0;
  localparam int RX_INVERTED = 1;
  localparam int RX_BAD = 2;
  localparam int RX_ANY = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [7:0] rx_crc;
  } word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] crc;
  } check_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic [7:0] in_received_crc = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_check_status;
  logic [7:0] out_computed_crc;

  word_t      word_q[$];
  check_t     check_q[$];
  logic [7:0] blk_bytes[$];
  logic [7:0] crc_acc = 8'h00;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  logic       hold_req = 1'b0;
  logic       hold_done = 1'b0;
  int         hold_left = 0;
  int         quiet_cycles = 0;
  int         fail_count = 0;
  int         phase_words;

  accessory_block_crc8_check uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .in_received_crc  (in_received_crc),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_check_status (out_check_status),
    .out_computed_crc (out_computed_crc)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // msb first, data bit enters at bit 0, poly folded in when the old top bit was set
  function automatic logic [7:0] crc8_feed(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic       top;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      top = r[7];
      r = {r[6:0], b[k]};
      if (top) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  // queues the bytes in blk_bytes as one block, choosing the trailing crc byte by mode
  task automatic send_block(input int rx_mode);
    logic [7:0] acc;
    logic [7:0] good;
    logic [7:0] rx;
    word_t      w;
    acc = 8'h00;
    foreach (blk_bytes[i]) acc = crc8_feed(acc, blk_bytes[i]);
    good = crc8_feed(acc, 8'h00);
    rx = 8'($urandom);
    case (rx_mode)
      RX_GOOD: rx = good;
      RX_INVERTED: rx = good ^ CRC_ALLONES;
      RX_BAD: begin
        if (rx == good || rx == (good ^ CRC_ALLONES)) rx = rx ^ 8'h01;
      end
      default: ;
    endcase
    foreach (blk_bytes[i]) begin
      w.data = blk_bytes[i];
      w.last = (i == blk_bytes.size() - 1);
      w.rx_crc = w.last ? rx : 8'($urandom);
      word_q.push_back(w);
    end
    phase_words += blk_bytes.size();
    blk_bytes.delete();
  endtask

  task automatic one_byte_block(input logic [7:0] b, input int rx_mode);
    blk_bytes.push_back(b);
    send_block(rx_mode);
  endtask

  task automatic random_blocks(input int count);
    int len;
    int pick;
    int mode;
    phase_words = 0;
    while (phase_words < count) begin
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(6, 1);
      else if (pick < 95) len = $urandom_range(20, 7);
      else len = $urandom_range(64, 21);
      for (int i = 0; i < len; i++) blk_bytes.push_back(8'($urandom));
      pick = $urandom_range(99);
      if (pick < 55) mode = RX_GOOD;
      else if (pick < 70) mode = RX_INVERTED;
      else if (pick < 85) mode = RX_BAD;
      else mode = RX_ANY;
      send_block(mode);
    end
  endtask

  task automatic drain();
    while (word_q.size() != 0 || in_valid) @(negedge clk);
    while (check_q.size() != 0) @(negedge clk);
  endtask

  // driver: accepted words update the predicted crc, then the next word is offered
  always @(posedge clk) begin : drive_words
    word_t      w;
    check_t     c;
    logic [7:0] fin;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        crc_acc = crc8_feed(crc_acc, in_data_byte);
        if (in_last_byte) begin
          fin = crc8_feed(crc_acc, 8'h00);
          if (fin == in_received_crc) c.status = ST_OK;
          else if (fin == (in_received_crc ^ CRC_ALLONES)) c.status = ST_NO_ACCESSORY;
          else c.status = ST_BAD_CRC;
          c.crc = fin;
          check_q.push_back(c);
          crc_acc = 8'h00;
        end
      end
      if (!in_valid || in_ready) begin
        if (word_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          w = word_q.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= w.data;
          in_last_byte <= w.last;
          in_received_crc <= w.rx_crc;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    check_t c;
    if (rst_n && out_valid && out_ready) begin
      if (check_q.size() == 0) begin
        $error("result word with no block pending: status %0d crc %02h",
               out_check_status, out_computed_crc);
        fail_count++;
      end else begin
        c = check_q.pop_front();
        if (out_check_status !== c.status) begin
          $error("check_status: expected %0d, got %0d", c.status, out_check_status);
          fail_count++;
        end
        if (out_computed_crc !== c.crc) begin
          $error("computed_crc: expected %02h, got %02h", c.crc, out_computed_crc);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: single-byte blocks at the extremes, every status, longer blocks
    tx_idle_pct <= 11;
    rx_idle_pct <= 70;
    phase_words = 0;
    one_byte_block(8'h00, RX_GOOD);
    one_byte_block(8'h00, RX_INVERTED);
    one_byte_block(8'hFF, RX_GOOD);
    one_byte_block(8'hFF, RX_INVERTED);
    one_byte_block(8'hFF, RX_BAD);
    one_byte_block(8'h80, RX_GOOD);
    one_byte_block(8'h01, RX_BAD);
    one_byte_block(8'h55, RX_INVERTED);
    blk_bytes = '{8'hFF, 8'hFF, 8'hFF};
    send_block(RX_GOOD);
    blk_bytes = '{8'h00, 8'h80, 8'h01, 8'hFF};
    send_block(RX_BAD);
    blk_bytes = '{8'hAA, 8'h55, 8'h00, 8'h00, 8'h7F};
    send_block(RX_INVERTED);
    drain();

    random_blocks(ITEMS_PER_PHASE);
    drain();

    tx_idle_pct <= 70;
    rx_idle_pct <= 11;
    random_blocks(ITEMS_PER_PHASE);
    drain();

    // no idling; receiver holds off long enough for the block to back up
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    hold_req <= 1'b1;
    random_blocks(ITEMS_PER_PHASE);
    drain();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (check_q.size() != 0) begin
      $error("%0d expected results never arrived", check_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
src/crc8c_pkg.sv
src/crc8c_in_stage.sv
src/crc8c_core.sv
src/accessory_block_crc8_check.sv
tb/tb_accessory_block_crc8_check.sv
